// File: hw/rtl/tirt_pkg.sv
`default_nettype none

package tirt_pkg;

  // Table geometry.
  localparam int unsigned MAX_IDS  = 64;
  localparam int unsigned KEY_BITS = 64;

  // Widths derived from the geometry.
  localparam int unsigned IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_IDS + 1);

  // Fixed port field widths.
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned KEY_IN_W  = 64;
  localparam int unsigned IDX_IN_W  = 6;
  localparam int unsigned EVT_W     = 3;
  localparam int unsigned ID_OUT_W  = 6;
  localparam int unsigned KEY_OUT_W = 64;

  // Common width for comparing a requested index with the fill count.
  localparam int unsigned REV_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP  = 2'd0,
    FUNC_REVERSE = 2'd1,
    FUNC_EVENT   = 2'd2
  } func_e;

  typedef enum logic [EVT_W-1:0] {
    EV_CREATED   = 3'd0,
    EV_TERMINATED = 3'd1,
    EV_FAILED    = 3'd2,
    EV_RESUMED   = 3'd3,
    EV_SUSPENDED = 3'd4,
    EV_OTHER     = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REV_DATA,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/thread_id_remap_table.sv
// A lookup compares the stored keys in order, one key per cycle through the single comparator
// behind the key store read port, and ends on the first match or once every key is compared.
// A reverse lookup of an assigned ID reads the key store before its result; other transactions
// go straight to the result. One transaction is in flight at a time: the next is accepted only
// once the result is taken. Reset clears the fill count, the process flags and the control
// state at once; the key store is not cleared, as it is read only below the fill.
`default_nettype none

module thread_id_remap_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tirt_pkg::FUNC_W-1:0]      func_i,
  input  logic [tirt_pkg::KEY_IN_W-1:0]    thread_key_i,
  input  logic [tirt_pkg::IDX_IN_W-1:0]    index_in_i,
  input  logic [tirt_pkg::EVT_W-1:0]       event_code_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tirt_pkg::ID_OUT_W-1:0]    id_out_o,
  output logic [tirt_pkg::KEY_OUT_W-1:0]   key_out_o,
  output logic                             hit_o,
  output logic                             newly_assigned_o,
  output logic                             table_full_o,
  output logic                             process_alive_o,
  output logic                             process_paused_o
);
  import tirt_pkg::*;

  // The key store: one write port (new assignments) and one registered read port that
  // is shared between the sequential scan and reverse lookups.
  logic [KEY_BITS-1:0] key_store [MAX_IDS];
  logic [KEY_BITS-1:0] rd_data_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                wr_en;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                alive_q, alive_d;
  logic                paused_q, paused_d;

  // Scan pointer (next entry to read) and the entry whose data sits in rd_data_q.
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [KEY_BITS-1:0] key_q, key_d;

  // Result registers.
  logic [ID_OUT_W-1:0]  res_id_q, res_id_d;
  logic [KEY_OUT_W-1:0] res_key_q, res_key_d;
  logic                 res_hit_q, res_hit_d;
  logic                 res_new_q, res_new_d;
  logic                 res_full_q, res_full_d;

  func_e  func;
  event_e evt;
  logic   in_accept;
  logic   rev_in_range;
  logic   scan_more;
  logic   scan_match;

  assign func         = func_e'(func_i);
  assign evt          = event_e'(event_code_i);
  assign in_accept    = in_valid_i && (state_q == ST_IDLE);
  assign rev_in_range = REV_W'(index_in_i) < REV_W'(fill_q);
  assign scan_more    = ptr_q < fill_q;
  assign scan_match   = cmp_vld_q && (rd_data_q == key_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (func)
            FUNC_LOOKUP:  state_d = ST_SCAN;
            FUNC_REVERSE: state_d = rev_in_range ? ST_REV_DATA : ST_OUT;
            default:      state_d = ST_OUT;
          endcase
        end
      end
      ST_SCAN: begin
        // Finished on a match, or once every stored entry has been compared.
        if (scan_match || !scan_more) begin
          state_d = ST_OUT;
        end
      end
      ST_REV_DATA: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    fill_d     = fill_q;
    alive_d    = alive_q;
    paused_d   = paused_q;
    ptr_d      = ptr_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    key_d      = key_q;
    res_id_d   = res_id_q;
    res_key_d  = res_key_q;
    res_hit_d  = res_hit_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    rd_addr    = ptr_q[IDX_W-1:0];
    wr_addr    = fill_q[IDX_W-1:0];
    wr_en      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        rd_addr = IDX_W'(index_in_i);
        if (in_accept) begin
          // Every field not defined by the function reads as zero.
          res_id_d   = '0;
          res_key_d  = '0;
          res_hit_d  = 1'b0;
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
          key_d      = thread_key_i[KEY_BITS-1:0];
          ptr_d      = '0;
          case (func)
            FUNC_EVENT: begin
              case (evt)
                EV_CREATED: begin
                  alive_d  = 1'b1;
                  paused_d = 1'b0;
                  fill_d   = '0;
                end
                EV_TERMINATED, EV_FAILED: begin
                  alive_d  = 1'b0;
                  paused_d = 1'b0;
                  fill_d   = '0;
                end
                EV_RESUMED:   paused_d = 1'b0;
                EV_SUSPENDED: paused_d = 1'b1;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Read the next entry while the previous one is compared.
        if (scan_more) begin
          ptr_d     = ptr_q + CNT_W'(1);
          cmp_idx_d = ptr_q;
          cmp_vld_d = 1'b1;
        end
        if (scan_match) begin
          res_hit_d = 1'b1;
          res_id_d  = ID_OUT_W'(cmp_idx_q);
        end else if (!scan_more) begin
          if (fill_q < CNT_W'(MAX_IDS)) begin
            wr_en     = 1'b1;
            fill_d    = fill_q + CNT_W'(1);
            res_new_d = 1'b1;
            res_id_d  = ID_OUT_W'(fill_q);
          end else begin
            res_full_d = 1'b1;
          end
        end
      end
      ST_REV_DATA: begin
        res_hit_d = 1'b1;
        res_key_d = KEY_OUT_W'(rd_data_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      alive_q   <= 1'b0;
      paused_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      alive_q   <= alive_d;
      paused_q  <= paused_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    cmp_idx_q  <= cmp_idx_d;
    key_q      <= key_d;
    res_id_q   <= res_id_d;
    res_key_q  <= res_key_d;
    res_hit_q  <= res_hit_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_store[wr_addr] <= key_q;
    end
    rd_data_q <= key_store[rd_addr];
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = (state_q == ST_OUT);
  assign id_out_o         = res_id_q;
  assign key_out_o        = res_key_q;
  assign hit_o            = res_hit_q;
  assign newly_assigned_o = res_new_q;
  assign table_full_o     = res_full_q;
  // The flags only change when a transaction is accepted, so they hold their
  // post-transaction value for as long as the result is shown.
  assign process_alive_o  = alive_q;
  assign process_paused_o = paused_q;

endmodule

`default_nettype wire

// File: hw/rtl/tirt_checker.sv
`default_nettype none

module tirt_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic [tirt_pkg::FUNC_W-1:0]      func_i,
  input  logic [tirt_pkg::EVT_W-1:0]       event_code_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [tirt_pkg::ID_OUT_W-1:0]    id_out_o,
  input  logic [tirt_pkg::KEY_OUT_W-1:0]   key_out_o,
  input  logic                             hit_o,
  input  logic                             newly_assigned_o,
  input  logic                             table_full_o,
  input  logic                             process_alive_o,
  input  logic                             process_paused_o
);
  import tirt_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(id_out_o) && $stable(key_out_o)
      && $stable(hit_o) && $stable(newly_assigned_o) && $stable(table_full_o))
    else $error("stalled result changed");

  // No new transaction is taken while a result waits.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while a result is pending");

  // A fresh assignment is never also a hit or a full table.
  a_new_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && newly_assigned_o |-> !hit_o && !table_full_o && key_out_o == '0)
    else $error("newly assigned combined with hit or full");

  // A full table reports no ID and no hit.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> !hit_o && id_out_o == '0 && key_out_o == '0)
    else $error("table full with a non-zero result");

  // A creation event leaves the process alive and running.
  a_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_EVENT && event_code_i == EV_CREATED
      |=> process_alive_o && !process_paused_o)
    else $error("creation event did not set the process flags");

endmodule

bind thread_id_remap_table tirt_checker u_tirt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .func_i           (func_i),
  .event_code_i     (event_code_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .id_out_o         (id_out_o),
  .key_out_o        (key_out_o),
  .hit_o            (hit_o),
  .newly_assigned_o (newly_assigned_o),
  .table_full_o     (table_full_o),
  .process_alive_o  (process_alive_o),
  .process_paused_o (process_paused_o)
);

`default_nettype wire

// File: dv/thread_remap_checker.sv
`default_nettype none

module thread_remap_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [tirt_pkg::FUNC_W-1:0]      func_i,
  input  logic [tirt_pkg::KEY_IN_W-1:0]    thread_key_i,
  input  logic [tirt_pkg::IDX_IN_W-1:0]    index_in_i,
  input  logic [tirt_pkg::EVT_W-1:0]       event_code_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [tirt_pkg::ID_OUT_W-1:0]    id_out_i,
  input  logic [tirt_pkg::KEY_OUT_W-1:0]   key_out_i,
  input  logic                             hit_i,
  input  logic                             newly_assigned_i,
  input  logic                             table_full_i,
  input  logic                             process_alive_i,
  input  logic                             process_paused_i,
  output int                               mismatch_count_o,
  output int                               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tirt_pkg::*;

  typedef struct packed {
    logic [ID_OUT_W-1:0]  id;
    logic [KEY_OUT_W-1:0] key;
    logic                 hit;
    logic                 fresh;
    logic                 full;
    logic                 alive;
    logic                 paused;
  } remap_result_t;

  // Shadow copy of the table and the process flags.
  logic [KEY_BITS-1:0] key_copy [MAX_IDS];
  int unsigned         ids_used = 0;
  logic                alive_q  = 1'b0;
  logic                paused_q = 1'b0;

  remap_result_t result_q [$];
  int            mismatches = 0;
  int            open_count = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = open_count;

  function automatic remap_result_t resolve_request(
    input logic [FUNC_W-1:0]   func,
    input logic [KEY_IN_W-1:0] key,
    input logic [IDX_IN_W-1:0] idx,
    input logic [EVT_W-1:0]    ev
  );
    remap_result_t       r;
    logic [KEY_BITS-1:0] k;
    bit                  found;
    r     = '0;
    k     = key[KEY_BITS-1:0];
    found = 1'b0;
    case (func)
      FUNC_LOOKUP: begin
        for (int i = 0; i < ids_used; i++) begin
          if (!found && key_copy[i] == k) begin
            found = 1'b1;
            r.id  = ID_OUT_W'(i);
          end
        end
        if (found) begin
          r.hit = 1'b1;
        end else if (ids_used < MAX_IDS) begin
          key_copy[ids_used] = k;
          r.id               = ID_OUT_W'(ids_used);
          r.fresh            = 1'b1;
          ids_used++;
        end else begin
          r.full = 1'b1;
        end
      end
      FUNC_REVERSE: begin
        if (idx < ids_used) begin
          r.key = KEY_OUT_W'(key_copy[idx]);
          r.hit = 1'b1;
        end
      end
      FUNC_EVENT: begin
        case (ev)
          EV_CREATED: begin
            alive_q  = 1'b1;
            paused_q = 1'b0;
            ids_used = 0;
          end
          EV_TERMINATED, EV_FAILED: begin
            alive_q  = 1'b0;
            paused_q = 1'b0;
            ids_used = 0;
          end
          EV_RESUMED:   paused_q = 1'b0;
          EV_SUSPENDED: paused_q = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.alive  = alive_q;
    r.paused = paused_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_used = 0;
      alive_q  = 1'b0;
      paused_q = 1'b0;
      result_q.delete();
      open_count = 0;
    end else begin
      // The result is taken before the new request is queued; with one
      // transaction in flight both cannot happen on the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%t: unexpected result, expected none, got id %0d key %h hit %b",
                   $time, id_out_i, key_out_i, hit_i);
          mismatches++;
        end else begin
          remap_result_t e;
          e = result_q.pop_front();
          check_field("id_out", 64'(e.id), 64'(id_out_i));
          check_field("key_out", 64'(e.key), 64'(key_out_i));
          check_field("hit", 64'(e.hit), 64'(hit_i));
          check_field("newly_assigned", 64'(e.fresh), 64'(newly_assigned_i));
          check_field("table_full", 64'(e.full), 64'(table_full_i));
          check_field("process_alive", 64'(e.alive), 64'(process_alive_i));
          check_field("process_paused", 64'(e.paused), 64'(process_paused_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        result_q.push_back(resolve_request(func_i, thread_key_i, index_in_i, event_code_i));
      end
      open_count = result_q.size();
    end
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tirt_pkg::*;

  // The function code 3 and the event codes above "other" have no name in the
  // package; they are legal field values that the block must ignore.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [EVT_W-1:0]  EV_CODE_LAST = 3'd7;

  // Rough stop point for the random part, counted in meaningful transactions.
  localparam int unsigned ITEM_TARGET = 1700;

  // Hold-off length for the receiver, long enough to back the block up.
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  in_valid_i       = 1'b0;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i           = '0;
  logic [KEY_IN_W-1:0]   thread_key_i     = '0;
  logic [IDX_IN_W-1:0]   index_in_i       = '0;
  logic [EVT_W-1:0]      event_code_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i      = 1'b0;
  logic [ID_OUT_W-1:0]   id_out_o;
  logic [KEY_OUT_W-1:0]  key_out_o;
  logic                  hit_o;
  logic                  newly_assigned_o;
  logic                  table_full_o;
  logic                  process_alive_o;
  logic                  process_paused_o;

  int mismatches;
  int outstanding;

  // Idle rates in percent of cycles for each side, changed per phase.
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 83;

  // Hold-off requests from the stimulus to the receiver process. Each side
  // writes only its own counter, so the hand-over cannot race.
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;
  int unsigned hold_left   = 0;

  // Keys that the table currently holds, as far as the stimulus is concerned.
  // This only steers the choice of keys towards hits; it predicts nothing.
  logic [KEY_IN_W-1:0] known_keys [$];
  int unsigned         items_done = 0;

  thread_id_remap_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .thread_key_i     (thread_key_i),
    .index_in_i       (index_in_i),
    .event_code_i     (event_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .id_out_o         (id_out_o),
    .key_out_o        (key_out_o),
    .hit_o            (hit_o),
    .newly_assigned_o (newly_assigned_o),
    .table_full_o     (table_full_o),
    .process_alive_o  (process_alive_o),
    .process_paused_o (process_paused_o)
  );

  thread_remap_checker remap_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .func_i           (func_i),
    .thread_key_i     (thread_key_i),
    .index_in_i       (index_in_i),
    .event_code_i     (event_code_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .id_out_i         (id_out_o),
    .key_out_i        (key_out_o),
    .hit_i            (hit_o),
    .newly_assigned_i (newly_assigned_o),
    .table_full_i     (table_full_o),
    .process_alive_i  (process_alive_o),
    .process_paused_i (process_paused_o),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. The slowest correct run (every lookup scanning a full table,
  // results held by the receiver most of the time, plus the hold-off) stays
  // well under two milliseconds, so ten gives ample margin.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver side. The stall changes at the falling edge only. A requested
  // hold-off is counted down here in cycles, so the sender keeps offering
  // transactions meanwhile and the block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [KEY_IN_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IDX_IN_W-1:0] rand_index();
    return IDX_IN_W'($urandom_range((1 << IDX_IN_W) - 1));
  endfunction

  function automatic logic [EVT_W-1:0] rand_event();
    return EVT_W'($urandom_range(EV_CODE_LAST));
  endfunction

  // A key the table is unlikely to hold: mostly random, sometimes one of the
  // extremes, sometimes a near miss that differs from a held key in one bit.
  function automatic logic [KEY_IN_W-1:0] unseen_key();
    logic [KEY_IN_W-1:0] k;
    int unsigned         pick;
    pick = $urandom_range(9);
    k    = rand_key();
    if (pick == 0) begin
      k = '0;
    end else if (pick == 1) begin
      k = '1;
    end else if (pick < 4 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
      k[$urandom_range(KEY_IN_W - 1)] ^= 1'b1;
    end
    return k;
  endfunction

  // Presents one transaction and returns at the falling edge after it has
  // been accepted. The sender may idle first; valid is never tied to stall.
  task automatic offer(
    input logic [FUNC_W-1:0]   f,
    input logic [KEY_IN_W-1:0] k,
    input logic [IDX_IN_W-1:0] ix,
    input logic [EVT_W-1:0]    ev
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    func_i       = f;
    thread_key_i = k;
    index_in_i   = ix;
    event_code_i = ev;
    in_valid_i   = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    // Created, terminated and failed all empty the table.
    if (f == FUNC_EVENT && ev <= EV_FAILED) known_keys.delete();
    if (!(f == FUNC_UNUSED || (f == FUNC_EVENT && ev >= EV_OTHER))) items_done++;
  endtask

  task automatic lookup_key(input logic [KEY_IN_W-1:0] k);
    offer(FUNC_LOOKUP, k, rand_index(), rand_event());
  endtask

  task automatic lookup_fresh();
    logic [KEY_IN_W-1:0] k;
    k = unseen_key();
    lookup_key(k);
    if (known_keys.size() < MAX_IDS) known_keys.push_back(k);
  endtask

  task automatic lookup_held();
    if (known_keys.size() == 0) begin
      lookup_fresh();
    end else begin
      lookup_key(known_keys[$urandom_range(known_keys.size() - 1)]);
    end
  endtask

  // Mostly asks for an assigned ID, otherwise for any ID at all.
  task automatic reverse_any();
    logic [IDX_IN_W-1:0] ix;
    ix = rand_index();
    if (known_keys.size() > 0 && $urandom_range(9) < 7) begin
      ix = IDX_IN_W'($urandom_range(known_keys.size() - 1));
    end
    offer(FUNC_REVERSE, rand_key(), ix, rand_event());
  endtask

  task automatic process_event(input logic [EVT_W-1:0] ev);
    offer(FUNC_EVENT, rand_key(), rand_index(), ev);
  endtask

  // Transactions that change nothing: the spare function code and the events
  // without effect.
  task automatic idle_noise();
    if ($urandom_range(1) == 0) begin
      offer(FUNC_UNUSED, rand_key(), rand_index(), rand_event());
    end else begin
      process_event(EVT_W'($urandom_range(EV_CODE_LAST, EV_OTHER)));
    end
  endtask

  // The sender stops and waits until every expected result has been taken.
  task automatic drain();
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  // One debugging session: usually opened by a creation event, with lookups,
  // reverse lookups and suspend/resume inside, and closed by a termination or a failure.
  // A flooding session assigns more new keys than the table can hold, so the
  // full case and scans of a full table are exercised.
  task automatic run_session(input bit flood);
    int unsigned n;
    int unsigned fresh;
    int unsigned r;
    process_event(($urandom_range(4) == 0) ? EV_TERMINATED : EV_CREATED);
    if (flood) begin
      n     = MAX_IDS + $urandom_range(8, 2);
      fresh = 0;
      while (fresh < n) begin
        r = $urandom_range(9);
        if (r == 0) begin
          reverse_any();
        end else if (r == 1) begin
          lookup_held();
        end else begin
          lookup_fresh();
          fresh++;
        end
      end
      repeat (4) lookup_held();
      repeat (4) reverse_any();
    end else begin
      n = $urandom_range(60, 5);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 25) begin
          lookup_held();
        end else if (r < 47) begin
          lookup_fresh();
        end else if (r < 67) begin
          reverse_any();
        end else if (r < 74) begin
          process_event(EV_SUSPENDED);
        end else if (r < 81) begin
          process_event(EV_RESUMED);
        end else if (r < 88) begin
          idle_noise();
        end else if (r < 91) begin
          // A session broken by an event that clears the table halfway.
          process_event(EVT_W'($urandom_range(EV_FAILED, EV_CREATED)));
        end else begin
          lookup_key(rand_key());
        end
      end
    end
    process_event(($urandom_range(1) == 0) ? EV_TERMINATED : EV_FAILED);
  endtask

  initial begin
    int unsigned phase;
    int unsigned cur_phase;
    bit          first;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Reverse lookups on the empty table, then the key
    // extremes, a repeated key for a hit, and an ID past the fill count.
    offer(FUNC_REVERSE, '1, '0, rand_event());
    offer(FUNC_REVERSE, '0, '1, rand_event());
    lookup_key('0);
    lookup_key('1);
    lookup_key('0);
    lookup_key({1'b1, {(KEY_IN_W - 2){1'b0}}, 1'b1});
    offer(FUNC_REVERSE, rand_key(), IDX_IN_W'(1), rand_event());
    offer(FUNC_REVERSE, rand_key(), IDX_IN_W'(2), rand_event());
    offer(FUNC_REVERSE, rand_key(), IDX_IN_W'(3), rand_event());
    offer(FUNC_UNUSED, '1, '1, '1);

    // Long receiver hold-off while the sender keeps going.
    holds_asked++;
    process_event(EV_SUSPENDED);
    process_event(EV_SUSPENDED);
    lookup_key('1);
    process_event(EV_RESUMED);
    process_event(EV_OTHER);
    process_event(EVT_W'(EV_CODE_LAST - 1));
    process_event(EV_CODE_LAST);

    // Clearing events: after creation the old IDs are gone and numbering
    // starts again from zero.
    process_event(EV_CREATED);
    offer(FUNC_REVERSE, rand_key(), '0, rand_event());
    lookup_key('1);
    process_event(EV_TERMINATED);
    process_event(EV_CREATED);
    process_event(EV_FAILED);
    drain();
    known_keys.delete();
    items_done = 0;

    // Random part in three idling phases: sender lightly and receiver
    // heavily idle, then the reverse, then no idling at all. The first
    // session always floods the table.
    cur_phase = 0;
    first     = 1'b1;
    while (items_done < ITEM_TARGET) begin
      phase = (items_done * 3) / ITEM_TARGET;
      if (phase != cur_phase) begin
        drain();
        cur_phase = phase;
        if (phase == 1) begin
          send_idle_pct = 83;
          recv_idle_pct = 29;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // One more hold-off with the sender running flat out.
          holds_asked++;
        end
      end
      run_session(first || $urandom_range(5) == 0);
      first = 1'b0;
    end

    // Every expected result must arrive; then the bench keeps watching for
    // anything spurious to show up.
    wait (outstanding == 0);
    repeat (2 * MAX_IDS + 8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/tirt_pkg.sv
hw/rtl/thread_id_remap_table.sv
hw/rtl/tirt_checker.sv
dv/thread_remap_checker.sv
dv/tb.sv
